>>> src/efps_pkg.sv
package efps_pkg;

   localparam int CSR_DATA_BITS = 48;
   localparam int SCREEN_BITS   = 13;
   localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [2:0] {
      CSR_VERTEX_A,
      CSR_VERTEX_B,
      CSR_VERTEX_C,
      CSR_SHADE_A,
      CSR_SHADE_B,
      CSR_SHADE_C,
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [23:0] pixel_address;
      logic [31:0] argb_color;
   } rsp_type;

endpackage

>>> src/efps_div.sv
module efps_div #(
   parameter int NW  = 54,
   parameter int DVW = 62
) (
   input  logic           clock,
   input  logic           en,
   input  logic [DVW-1:0] dividend,
   input  logic [NW-1:0]  divisor,
   output logic [7:0]     quot
);
   // Restoring division, one quotient bit per stage. Only the low eight
   // quotient bits are kept. A zero divisor always subtracts, so every
   // quotient bit comes out one.
   logic [NW-1:0]  rem_ff [DVW];
   logic [DVW-1:0] dvd_ff [DVW];
   logic [NW-1:0]  dsr_ff [DVW];
   logic [7:0]     q_ff   [DVW];

   genvar k;
   generate
      for (k = 0; k < DVW; k++) begin : g_stage
         logic [NW-1:0]  rem_prev;
         logic [DVW-1:0] dvd_prev;
         logic [NW-1:0]  dsr_prev;
         logic [7:0]     q_prev;
         logic [NW:0]    shifted;
         logic [NW+1:0]  diff;
         logic           take;
         logic [NW-1:0]  rem_in;
         logic [7:0]     q_in;

         if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign dvd_prev = dividend;
            assign dsr_prev = divisor;
            assign q_prev   = '0;
         end else begin : g_rest
            assign rem_prev = rem_ff[k-1];
            assign dvd_prev = dvd_ff[k-1];
            assign dsr_prev = dsr_ff[k-1];
            assign q_prev   = q_ff[k-1];
         end

         always_comb begin
            shifted = {rem_prev, dvd_prev[DVW-1]};
            diff    = {1'b0, shifted} - {2'b00, dsr_prev};
            take    = !diff[NW+1];
            rem_in  = take ? diff[NW-1:0] : shifted[NW-1:0];
            q_in    = {q_prev[6:0], take};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               dvd_ff[k] <= dvd_prev << 1;
               dsr_ff[k] <= dsr_prev;
               q_ff[k]   <= q_in;
            end
         end
      end
   endgenerate

   assign quot = q_ff[DVW-1];

endmodule

>>> src/edge_function_pixel_shade.sv
// Channel  Ports                                   Moves
// req      req_valid / req_stall / req_data        pixel column and row
// rsp      rsp_valid / rsp_stall / rsp_data        address and ARGB of covered pixel
// csr      csr_valid / csr_ready / csr_index/data  triangle and screen registers
//
// One pixel enters per cycle while rsp is not stalled. Stages in order: edge differences,
// products, edge sums, weight products, weighted sums, then a restoring
// divider with one quotient bit per stage (DVW = 62 at the default).
// Reset is synchronous; it clears valid bits and sets the CSR registers to their reset values.
// A stalled result holds the whole pipeline; uncovered pixels leave as bubbles.
module edge_function_pixel_shade #(
   parameter int SUBPIXEL_BITS = 4,
   parameter int ADDRESS_BITS  = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  efps_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output efps_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  efps_pkg::csr_index_type                csr_index,
   input  logic [efps_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import efps_pkg::*;

   localparam int CW  = (13 + SUBPIXEL_BITS > 17) ? 13 + SUBPIXEL_BITS : 17;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * DW;
   localparam int EW  = PW + 1;
   localparam int WW  = EW - 1;
   localparam int TW  = WW + 16;
   localparam int NW  = TW + 2;
   localparam int DVW = (NW + 8 > 64) ? 64 : NW + 8;
   localparam logic [23:0] AMASK = 24'((64'd1 << ADDRESS_BITS) - 64'd1);

   // configuration
   logic [CSR_DATA_BITS-1:0] vertex_ff [3];
   logic [CSR_DATA_BITS-1:0] shade_ff  [3];
   logic [SCREEN_BITS-1:0]   width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_ff[0] <= '0;
         vertex_ff[1] <= '0;
         vertex_ff[2] <= '0;
         shade_ff[0]  <= '0;
         shade_ff[1]  <= '0;
         shade_ff[2]  <= '0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_VERTEX_A:      vertex_ff[0] <= csr_data;
            CSR_VERTEX_B:      vertex_ff[1] <= csr_data;
            CSR_VERTEX_C:      vertex_ff[2] <= csr_data;
            CSR_SHADE_A:       shade_ff[0]  <= csr_data;
            CSR_SHADE_B:       shade_ff[1]  <= csr_data;
            CSR_SHADE_C:       shade_ff[2]  <= csr_data;
            CSR_SCREEN_WIDTH:  width_ff     <= csr_data[SCREEN_BITS-1:0];
            CSR_SCREEN_HEIGHT: height_ff    <= csr_data[SCREEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // global advance
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // triangle geometry from registers (user must keep static while pixels are in flight; not enforced)
   logic [CW-1:0]        vx [3];
   logic [CW-1:0]        vy [3];
   logic signed [DW-1:0] kx [4];
   logic signed [DW-1:0] ky [4];
   logic [CW-1:0]        ax [4];
   logic [CW-1:0]        ay [4];
   logic [CW-1:0]        px, py;
   logic [SCREEN_BITS-1:0] wd, ht, wm1, hm1, cx, cy;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vx[i] = CW'({vertex_ff[i][47:32], 1'b0});
         vy[i] = CW'({vertex_ff[i][31:16], 1'b0});
      end
      // edges 0..2 use (v1,v2), (v2,v0), (v0,v1); slot 3 is the area
      ax[0] = vx[1]; ay[0] = vy[1];
      ax[1] = vx[2]; ay[1] = vy[2];
      ax[2] = vx[0]; ay[2] = vy[0];
      ax[3] = vx[0]; ay[3] = vy[0];
      kx[0] = $signed({1'b0, vx[2]}) - $signed({1'b0, vx[1]});
      ky[0] = $signed({1'b0, vy[2]}) - $signed({1'b0, vy[1]});
      kx[1] = $signed({1'b0, vx[0]}) - $signed({1'b0, vx[2]});
      ky[1] = $signed({1'b0, vy[0]}) - $signed({1'b0, vy[2]});
      kx[2] = $signed({1'b0, vx[1]}) - $signed({1'b0, vx[0]});
      ky[2] = $signed({1'b0, vy[1]}) - $signed({1'b0, vy[0]});
      kx[3] = kx[2];
      ky[3] = ky[2];
      px = CW'({req_data.pixel_x, 1'b1}) << SUBPIXEL_BITS;
      py = CW'({req_data.pixel_y, 1'b1}) << SUBPIXEL_BITS;
      wd  = (width_ff == '0) ? SCREEN_BITS'(1) : width_ff;
      ht  = (height_ff == '0) ? SCREEN_BITS'(1) : height_ff;
      wm1 = wd - SCREEN_BITS'(1);
      hm1 = ht - SCREEN_BITS'(1);
      cx  = ({1'b0, req_data.pixel_x} >= wm1) ? wm1 : {1'b0, req_data.pixel_x};
      cy  = ({1'b0, req_data.pixel_y} >= hm1) ? hm1 : {1'b0, req_data.pixel_y};
   end

   // stage A: differences to the first edge point
   logic                   va_ff;
   logic signed [DW-1:0]   dpx_ff [4];
   logic signed [DW-1:0]   dpy_ff [4];
   logic [SCREEN_BITS-1:0] cxa_ff, cya_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            dpx_ff[j] <= $signed({1'b0, px}) - $signed({1'b0, ax[j]});
            dpy_ff[j] <= $signed({1'b0, py}) - $signed({1'b0, ay[j]});
         end
         dpx_ff[3] <= $signed({1'b0, vx[2]}) - $signed({1'b0, ax[3]});
         dpy_ff[3] <= $signed({1'b0, vy[2]}) - $signed({1'b0, ay[3]});
         cxa_ff <= cx;
         cya_ff <= cy;
      end
   end

   // stage B: cross products
   logic                        vb_ff;
   logic signed [PW-1:0]        m1_ff [4];
   logic signed [PW-1:0]        m2_ff [4];
   logic [2*SCREEN_BITS-1:0]    rowb_ff;
   logic [SCREEN_BITS-1:0]      cxb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            m1_ff[j] <= dpx_ff[j] * ky[j];
            m2_ff[j] <= dpy_ff[j] * kx[j];
         end
         rowb_ff <= cya_ff * wd;
         cxb_ff  <= cxa_ff;
      end
   end

   // stage C: edge values and address
   logic                 vc_ff;
   logic signed [EW-1:0] e_ff [4];
   logic [23:0]          addrc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            e_ff[j] <= EW'(m1_ff[j]) - EW'(m2_ff[j]);
         end
         addrc_ff <= 24'(27'(rowb_ff) + 27'(cxb_ff)) & AMASK;
      end
   end

   // coverage: nonzero area and no negative edge
   logic covered;
   assign covered = vc_ff && (e_ff[3] != '0) &&
                    !e_ff[0][EW-1] && !e_ff[1][EW-1] && !e_ff[2][EW-1];

   // stage D: weight products
   logic          vd_ff;
   logic [TW-1:0] ct_ff [3][3];
   logic [TW-1:0] dt_ff [3];
   logic [23:0]   addrd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en) begin
         vd_ff <= covered;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
               ct_ff[i][c] <= e_ff[i][WW-1:0] * shade_ff[i][c*16 +: 16];
            end
            dt_ff[i] <= e_ff[i][WW-1:0] * vertex_ff[i][15:0];
         end
         addrd_ff <= addrc_ff;
      end
   end

   // stage E: weighted sums, dividend scaled by 256
   logic           ve_ff;
   logic [DVW-1:0] num_ff [3];
   logic [NW-1:0]  den_ff;
   logic [23:0]    addre_ff;
   logic [NW-1:0]  nsum [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         nsum[c] = NW'(ct_ff[0][c]) + NW'(ct_ff[1][c]) + NW'(ct_ff[2][c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (en) begin
         ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            num_ff[c] <= DVW'({nsum[c], 8'd0});
         end
         den_ff   <= NW'(dt_ff[0]) + NW'(dt_ff[1]) + NW'(dt_ff[2]);
         addre_ff <= addrd_ff;
      end
   end

   // dividers, one per channel: 0 blue, 1 green, 2 red
   logic [7:0] chan [3];

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_chan
         efps_div #(
            .NW  (NW),
            .DVW (DVW)
         ) u_div (
            .clock    (clock),
            .en       (en),
            .dividend (num_ff[g]),
            .divisor  (den_ff),
            .quot     (chan[g])
         );
      end
   endgenerate

   // valid and address ride alongside the divider
   logic        vq_ff [DVW];
   logic [23:0] aq_ff [DVW];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DVW; k++) begin
            vq_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vq_ff[0] <= ve_ff;
         for (int k = 1; k < DVW; k++) begin
            vq_ff[k] <= vq_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aq_ff[0] <= addre_ff;
         for (int k = 1; k < DVW; k++) begin
            aq_ff[k] <= aq_ff[k-1];
         end
      end
   end

   assign rsp_valid              = vq_ff[DVW-1];
   assign rsp_data.pixel_address = aq_ff[DVW-1];
   assign rsp_data.argb_color    = {ALPHA_OPAQUE, chan[2], chan[1], chan[0]};

endmodule
